// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== src/jmss_pkg.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment scanner package
// Scan phase codes, stop reasons, result kinds, marker byte values and the start position.
// ----------------------------------------------------------------------------
`default_nettype none

package jmss_pkg;

  localparam logic [2:0] PH_SOI0   = 3'd0;
  localparam logic [2:0] PH_SOI1   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_MARKER = 3'd3;
  localparam logic [2:0] PH_LENHI  = 3'd4;
  localparam logic [2:0] PH_LENLO  = 3'd5;

  localparam logic [2:0] RSN_NO_SOI      = 3'd0;
  localparam logic [2:0] RSN_BAD_PREFIX  = 3'd1;
  localparam logic [2:0] RSN_SOS         = 3'd2;
  localparam logic [2:0] RSN_HDR_PAST    = 3'd3;
  localparam logic [2:0] RSN_LIMIT       = 3'd4;
  localparam logic [2:0] RSN_SHORT_LEN   = 3'd5;
  localparam logic [2:0] RSN_DATA_ENDED  = 3'd6;

  localparam logic KIND_APP1 = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  localparam logic [7:0] MRK_FILL = 8'hFF;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_SOS  = 8'hDA;
  localparam logic [7:0] MRK_APP1 = 8'hE1;

  localparam logic [31:0] START_NEXT_POS = 32'd2;

endpackage

`default_nettype wire

// ===== src/jpeg_marker_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment scanner
// Walks the marker segments of a JPEG byte stream, reports APP1 segments and the stop reason.
// ----------------------------------------------------------------------------
// The input channel takes one file byte per request together with a flag that
// marks the final byte of the file. The output channel carries either an APP1
// result (payload offset and length) or one stop result with its reason.
// The file length register is written through cfg_wr_en_i and cfg_wr_data_i;
// the user must do so only while the block is idle; the block does not enforce it.
// Every byte is handled in the cycle it is accepted, and its result, if any,
// is presented from the output register in the next cycle. One byte can be
// accepted in every cycle; the single output register sets that figure, so
// input is stalled only while a result sits there and the receiver stalls.
// After reset the scan expects the first byte of a file and the output is
// empty. After a byte flagged as final, the scan state returns to that same
// starting point while the file length is kept.
`default_nettype none

`include "assert_macros.svh"

module jpeg_marker_segment_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [31:0]      payload_offset_o,
  output logic [15:0]      payload_length_o,
  output logic [2:0]       stop_reason_o
);
  import jmss_pkg::*;

  logic [31:0] file_length_q;
  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  marker_q, marker_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [31:0] next_pos_q, next_pos_d;
  logic        stopped_q, stopped_d;

  logic        out_valid_q;
  logic        kind_q;
  logic [31:0] offset_q;
  logic [15:0] length_q;
  logic [2:0]  reason_q;

  logic        res_vld;
  logic        res_kind;
  logic [31:0] res_off;
  logic [15:0] res_len;
  logic [2:0]  res_rsn;

  logic [31:0] lim;
  logic [32:0] pos_p3;
  logic [15:0] seg;
  logic [32:0] seg_end;
  logic        out_free;
  logic        accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign accept     = in_valid_i && out_free;

  always_comb begin
    lim     = (file_length_q >= 32'd2) ? (file_length_q - 32'd2) : 32'd0;
    pos_p3  = {1'b0, pos_q} + 33'd3;
    seg     = {len_hi_q, data_byte_i};
    seg_end = {1'b0, pos_q} + {17'd0, seg} - 33'd1;

    pos_d      = pos_q + 32'd1;
    phase_d    = phase_q;
    marker_d   = marker_q;
    len_hi_d   = len_hi_q;
    next_pos_d = next_pos_q;
    stopped_d  = stopped_q;

    res_vld  = 1'b0;
    res_kind = KIND_STOP;
    res_off  = 32'd0;
    res_len  = 16'd0;
    res_rsn  = RSN_NO_SOI;

    if (!stopped_q) begin
      unique case (phase_q)
        PH_SOI0: begin
          if (file_length_q < 32'd2 || data_byte_i != MRK_FILL) begin
            res_vld   = 1'b1;
            res_rsn   = RSN_NO_SOI;
            stopped_d = 1'b1;
          end else begin
            phase_d = PH_SOI1;
          end
        end
        PH_SOI1: begin
          if (data_byte_i != MRK_SOI) begin
            res_vld   = 1'b1;
            res_rsn   = RSN_NO_SOI;
            stopped_d = 1'b1;
          end else begin
            phase_d    = PH_PREFIX;
            next_pos_d = START_NEXT_POS;
          end
        end
        PH_PREFIX: begin
          if (pos_q == next_pos_q) begin
            if (pos_q >= lim) begin
              res_vld   = 1'b1;
              res_rsn   = RSN_LIMIT;
              stopped_d = 1'b1;
            end else if (data_byte_i != MRK_FILL) begin
              res_vld   = 1'b1;
              res_rsn   = RSN_BAD_PREFIX;
              stopped_d = 1'b1;
            end else begin
              phase_d = PH_MARKER;
            end
          end
        end
        PH_MARKER: begin
          if (data_byte_i == MRK_FILL) begin
            if (pos_q >= lim) begin
              res_vld   = 1'b1;
              res_rsn   = RSN_LIMIT;
              stopped_d = 1'b1;
            end
          end else if (data_byte_i == MRK_SOS) begin
            res_vld   = 1'b1;
            res_rsn   = RSN_SOS;
            stopped_d = 1'b1;
          end else if (pos_p3 >= {1'b0, lim}) begin
            res_vld   = 1'b1;
            res_rsn   = RSN_HDR_PAST;
            stopped_d = 1'b1;
          end else begin
            marker_d = data_byte_i;
            phase_d  = PH_LENHI;
          end
        end
        PH_LENHI: begin
          len_hi_d = data_byte_i;
          phase_d  = PH_LENLO;
        end
        default: begin
          if (seg < 16'd2) begin
            res_vld   = 1'b1;
            res_rsn   = RSN_SHORT_LEN;
            stopped_d = 1'b1;
          end else begin
            if (marker_q == MRK_APP1 && seg_end <= {1'b0, lim}) begin
              res_vld  = 1'b1;
              res_kind = KIND_APP1;
              res_off  = pos_q + 32'd1;
              res_len  = seg - 16'd2;
              res_rsn  = RSN_NO_SOI;
            end
            next_pos_d = seg_end[32] ? 32'hFFFF_FFFF : seg_end[31:0];
            phase_d    = PH_PREFIX;
          end
        end
      endcase
    end

    if (last_byte_i) begin
      if (!stopped_d) begin
        res_vld  = 1'b1;
        res_kind = KIND_STOP;
        res_off  = 32'd0;
        res_len  = 16'd0;
        res_rsn  = (phase_d == PH_PREFIX && next_pos_d >= lim) ? RSN_LIMIT
                                                                : RSN_DATA_ENDED;
      end
      pos_d      = 32'd0;
      phase_d    = PH_SOI0;
      marker_d   = 8'd0;
      len_hi_d   = 8'd0;
      next_pos_d = START_NEXT_POS;
      stopped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= 32'd0;
      pos_q         <= 32'd0;
      phase_q       <= PH_SOI0;
      marker_q      <= 8'd0;
      len_hi_q      <= 8'd0;
      next_pos_q    <= START_NEXT_POS;
      stopped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        file_length_q <= cfg_wr_data_i;
      end
      if (accept) begin
        pos_q      <= pos_d;
        phase_q    <= phase_d;
        marker_q   <= marker_d;
        len_hi_q   <= len_hi_d;
        next_pos_q <= next_pos_d;
        stopped_q  <= stopped_d;
      end
      if (out_free) begin
        out_valid_q <= accept && res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_vld) begin
      kind_q   <= res_kind;
      offset_q <= res_off;
      length_q <= res_len;
      reason_q <= res_rsn;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign payload_offset_o = offset_q;
  assign payload_length_o = length_q;
  assign stop_reason_o    = reason_q;

  `ASSERT_SAME(a_stop_has_no_payload, clk_i, rst_ni,
               out_valid_o && result_kind_o == KIND_STOP,
               payload_offset_o == 32'd0 && payload_length_o == 16'd0)

  `ASSERT_SAME(a_app1_has_no_reason, clk_i, rst_ni,
               out_valid_o && result_kind_o == KIND_APP1,
               stop_reason_o == RSN_NO_SOI)

  `ASSERT_NEXT(a_rearm_after_last, clk_i, rst_ni,
               accept && last_byte_i,
               pos_q == 32'd0 && phase_q == PH_SOI0 && !stopped_q)

  `ASSERT_NEXT(a_stop_is_sticky, clk_i, rst_ni,
               stopped_q && !(accept && last_byte_i),
               stopped_q)

endmodule

`default_nettype wire
